// File: hdl/vbad_pkg.sv
// Shared constants, types and width helpers for the volume box-average downsampler.
package vbad_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_FACTOR = 8;

  localparam int VOXEL_W    = 16;
  localparam int COORD_W    = 10;
  localparam int FACTOR_W   = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int DEPTH_W    = 11;
  localparam int SLICE_W    = 10;
  localparam int DEPTH_LIMIT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd3;

  localparam int RST_FACTOR = 2;
  localparam int RST_WIDTH  = 512;
  localparam int RST_HEIGHT = 512;
  localparam int RST_DEPTH  = 256;

  // Position of a cube and where the current voxel sits inside it.
  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] os;
    logic               done;
    logic               first;
    logic               last;
  } cube_tag_t;

  // Partial sum width: one voxel times the largest cube, plus sign.
  function automatic int sum_width(int max_factor);
    return VOXEL_W + 1 + $clog2(max_factor * max_factor * max_factor);
  endfunction

  // Entries needed for one output slice; factor one never reads back.
  function automatic int sum_depth(int max_width, int max_factor);
    return (max_factor > 1) ? (max_width >> 1) * (max_width >> 1) : 2;
  endfunction

endpackage

// File: hdl/volume_box_average_downsampler_core.sv
// Top level of the volume box-average downsampler: configuration, pipeline and output stage.
// Voxels stream in at one per cycle in raster order (column, then row, then slice); each
// factor-cubed block is summed in a partial-sum memory of (MAX_WIDTH/2)^2 entries, one per
// output column and row of the current output slice, read and written back each cycle with
// forwarding for back-to-back hits on the same entry. After the block's last voxel is
// accepted, its mean passes through a four-stage reciprocal divider and an output register.
// Input is held off only while a finished mean waits behind an output register that is not
// being taken. The memory needs no clearing: an entry is always written on its block's first
// voxel. A valid write to any of the four registers restarts the volume at its first voxel.
module volume_box_average_downsampler_core
  import vbad_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] voxel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [15:0] avg_value, [25:16] out_col,
                                            // [35:26] out_row, [45:36] out_slice, zero pad
  output logic                  out_tlast,  // volume_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = sum_width(MAX_FACTOR);
  localparam int ADDR_W = $clog2(sum_depth(MAX_WIDTH, MAX_FACTOR));
  localparam int RST_F  = (RST_FACTOR > MAX_FACTOR) ? MAX_FACTOR : RST_FACTOR;
  localparam int RST_W  = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int RST_H  = (RST_HEIGHT > MAX_WIDTH) ? MAX_WIDTH : RST_HEIGHT;

  // configuration, stored already clamped
  logic [FW-1:0]      factor_r, factor_nxt;
  logic [WW-1:0]      width_r, width_nxt;
  logic [WW-1:0]      height_r, height_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               restart;

  logic                      en, in_fire;
  logic [ADDR_W-1:0]         gen_addr;
  logic                      gen_hit;
  cube_tag_t                 gen_tag;
  logic                      acc_v;
  logic signed [SUM_W-1:0]   acc_sum;
  cube_tag_t                 acc_tag;
  logic                      div_v;
  logic signed [VOXEL_W-1:0] div_q;
  cube_tag_t                 div_tag;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic        out_tlast_r;

  int cfg_i;

  always_comb begin
    cfg_i      = int'(cfg_data);
    restart    = cfg_valid && cfg_ready && (cfg_index <= REG_DEPTH);
    factor_nxt = factor_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FACTOR: begin
          if (cfg_data[FACTOR_W-1:0] == '0) begin
            factor_nxt = FW'(1);
          end else if (int'(cfg_data[FACTOR_W-1:0]) > MAX_FACTOR) begin
            factor_nxt = FW'(MAX_FACTOR);
          end else begin
            factor_nxt = FW'(cfg_data[FACTOR_W-1:0]);
          end
        end
        REG_WIDTH: begin
          width_nxt = (cfg_i == 0) ? WW'(1) :
                      (cfg_i > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
        end
        REG_HEIGHT: begin
          height_nxt = (cfg_i == 0) ? WW'(1) :
                       (cfg_i > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
        end
        REG_DEPTH: begin
          depth_nxt = (cfg_i == 0) ? DEPTH_W'(1) :
                      (cfg_i > DEPTH_LIMIT) ? DEPTH_W'(DEPTH_LIMIT) : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FW'(RST_F);
      width_r  <= WW'(RST_W);
      height_r <= WW'(RST_H);
      depth_r  <= DEPTH_W'(RST_DEPTH);
    end else begin
      factor_r <= factor_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // whole pipeline freezes only when a mean is ready and the output register is blocked
  assign en        = !(out_tvalid_r && !out_tready && div_v);
  assign in_tready = en;
  assign in_fire   = in_tvalid && in_tready;

  vbad_addr_gen #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_addr_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .restart(restart),
    .step   (in_fire),
    .f      (factor_r),
    .w      (width_r),
    .h      (height_r),
    .d      (depth_r),
    .addr   (gen_addr),
    .hit    (gen_hit),
    .tag    (gen_tag)
  );

  vbad_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_fire && gen_hit),
    .in_addr (gen_addr),
    .in_voxel(in_tdata),
    .in_tag  (gen_tag),
    .out_v   (acc_v),
    .out_sum (acc_sum),
    .out_tag (acc_tag)
  );

  vbad_div #(
    .MAX_FACTOR(MAX_FACTOR)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .f      (factor_r),
    .in_v   (acc_v),
    .in_sum (acc_sum),
    .in_tag (acc_tag),
    .out_v  (div_v),
    .out_q  (div_q),
    .out_tag(div_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en && div_v) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && div_v) begin
      out_tdata_r <= {2'b00, div_tag.os, div_tag.oy, div_tag.ox, div_q};
      out_tlast_r <= div_tag.done;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // a register write puts the next voxel at the corner of a new block
  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> gen_tag.first)
    else $error("position not cleared after register write");

  // a voxel can open and close its block only for unit factor
  a_unit_cube: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && gen_tag.first && gen_tag.last) |-> (factor_r == FW'(1)))
    else $error("single-voxel block with factor above one");

  // a finished mean that moves on is presented at the output
  a_mean_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (en && div_v) |=> out_tvalid)
    else $error("divider result lost before output register");

endmodule

// File: hdl/vbad_addr_gen.sv
// Raster position tracking: cube offsets, cube coordinates and partial-sum address.
module vbad_addr_gen
  import vbad_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          restart,
  input  logic                                          step,
  input  logic [$clog2(MAX_FACTOR+1)-1:0]               f,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                w,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                h,
  input  logic [DEPTH_W-1:0]                            d,
  output logic [$clog2(sum_depth(MAX_WIDTH, MAX_FACTOR))-1:0] addr,
  output logic                                          hit,
  output cube_tag_t                                     tag
);

  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int LW     = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = WW + 2;
  localparam int SEW    = DEPTH_W + 2;
  localparam int ADDR_W = $clog2(sum_depth(MAX_WIDTH, MAX_FACTOR));

  logic [LW-1:0]      lx_r, ly_r, lz_r;
  logic [LW-1:0]      lx_nxt, ly_nxt, lz_nxt;
  logic [XW-1:0]      ox_r, oy_r, cbase_r, rbase_r;
  logic [XW-1:0]      ox_nxt, oy_nxt, cbase_nxt, rbase_nxt;
  logic [SLICE_W-1:0] os_r, sbase_r, os_nxt, sbase_nxt;
  logic [WW-1:0]      wcnt_r, wcnt_nxt, wcnt_val;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt;

  logic [LW-1:0]  f_last;
  logic [EW-1:0]  f_e, w_e, h_e, cb_e, rb_e;
  logic [SEW-1:0] f_s, d_s, sb_s;
  logic           col_hit, row_hit, sl_hit;
  logic           col_fin, row_fin, sl_fin;
  logic           col_end, row_end, sl_end;
  logic           lx_end, ly_end, lz_end;

  always_comb begin
    f_last = LW'(f - FW'(1));
    f_e    = EW'(f);
    w_e    = EW'(w);
    h_e    = EW'(h);
    cb_e   = EW'(cbase_r);
    rb_e   = EW'(rbase_r);
    f_s    = SEW'(f);
    d_s    = SEW'(d);
    sb_s   = SEW'(sbase_r);

    col_hit = (cb_e + f_e) <= w_e;
    row_hit = (rb_e + f_e) <= h_e;
    sl_hit  = (sb_s + f_s) <= d_s;
    // last whole cube along an axis: the next one would not fit
    col_fin = (cb_e + f_e + f_e) > w_e;
    row_fin = (rb_e + f_e + f_e) > h_e;
    sl_fin  = (sb_s + f_s + f_s) > d_s;

    col_end = (cb_e + EW'(lx_r) + EW'(1)) >= w_e;
    row_end = (rb_e + EW'(ly_r) + EW'(1)) >= h_e;
    sl_end  = (sb_s + SEW'(lz_r) + SEW'(1)) >= d_s;
    lx_end  = lx_r == f_last;
    ly_end  = ly_r == f_last;
    lz_end  = lz_r == f_last;

    hit       = col_hit && row_hit && sl_hit;
    tag.ox    = COORD_W'(ox_r);
    tag.oy    = COORD_W'(oy_r);
    tag.os    = COORD_W'(os_r);
    tag.done  = col_fin && row_fin && sl_fin;
    tag.first = (lx_r == '0) && (ly_r == '0) && (lz_r == '0);
    tag.last  = lx_end && ly_end && lz_end;
    addr      = row_addr_r + ADDR_W'(ox_r);

    // cube columns seen so far in this row; equals the output width at row end
    wcnt_val = wcnt_r + WW'((lx_r == '0) && col_hit);

    lx_nxt       = lx_r;
    ox_nxt       = ox_r;
    cbase_nxt    = cbase_r;
    ly_nxt       = ly_r;
    oy_nxt       = oy_r;
    rbase_nxt    = rbase_r;
    lz_nxt       = lz_r;
    os_nxt       = os_r;
    sbase_nxt    = sbase_r;
    wcnt_nxt     = wcnt_r;
    row_addr_nxt = row_addr_r;

    if (restart) begin
      lx_nxt       = '0;
      ox_nxt       = '0;
      cbase_nxt    = '0;
      ly_nxt       = '0;
      oy_nxt       = '0;
      rbase_nxt    = '0;
      lz_nxt       = '0;
      os_nxt       = '0;
      sbase_nxt    = '0;
      wcnt_nxt     = '0;
      row_addr_nxt = '0;
    end else if (step) begin
      if (col_end) begin
        lx_nxt    = '0;
        ox_nxt    = '0;
        cbase_nxt = '0;
        wcnt_nxt  = '0;
        if (row_end) begin
          ly_nxt       = '0;
          oy_nxt       = '0;
          rbase_nxt    = '0;
          row_addr_nxt = '0;
          if (sl_end) begin
            lz_nxt    = '0;
            os_nxt    = '0;
            sbase_nxt = '0;
          end else if (lz_end) begin
            lz_nxt    = '0;
            os_nxt    = os_r + SLICE_W'(1);
            sbase_nxt = SLICE_W'(sb_s + f_s);
          end else begin
            lz_nxt = lz_r + LW'(1);
          end
        end else if (ly_end) begin
          ly_nxt       = '0;
          oy_nxt       = oy_r + XW'(1);
          rbase_nxt    = XW'(rb_e + f_e);
          row_addr_nxt = row_addr_r + ADDR_W'(wcnt_val);
        end else begin
          ly_nxt = ly_r + LW'(1);
        end
      end else begin
        wcnt_nxt = wcnt_val;
        if (lx_end) begin
          lx_nxt    = '0;
          ox_nxt    = ox_r + XW'(1);
          cbase_nxt = XW'(cb_e + f_e);
        end else begin
          lx_nxt = lx_r + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r       <= '0;
      ox_r       <= '0;
      cbase_r    <= '0;
      ly_r       <= '0;
      oy_r       <= '0;
      rbase_r    <= '0;
      lz_r       <= '0;
      os_r       <= '0;
      sbase_r    <= '0;
      wcnt_r     <= '0;
      row_addr_r <= '0;
    end else begin
      lx_r       <= lx_nxt;
      ox_r       <= ox_nxt;
      cbase_r    <= cbase_nxt;
      ly_r       <= ly_nxt;
      oy_r       <= oy_nxt;
      rbase_r    <= rbase_nxt;
      lz_r       <= lz_nxt;
      os_r       <= os_nxt;
      sbase_r    <= sbase_nxt;
      wcnt_r     <= wcnt_nxt;
      row_addr_r <= row_addr_nxt;
    end
  end

endmodule

// File: hdl/vbad_accum.sv
// Partial-sum memory with read-modify-write and write-to-read forwarding.
module vbad_accum
  import vbad_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_v,
  input  logic [$clog2(sum_depth(MAX_WIDTH, MAX_FACTOR))-1:0] in_addr,
  input  logic signed [VOXEL_W-1:0]                          in_voxel,
  input  cube_tag_t                                          in_tag,
  output logic                                               out_v,
  output logic signed [sum_width(MAX_FACTOR)-1:0]            out_sum,
  output cube_tag_t                                          out_tag
);

  localparam int SUM_W  = sum_width(MAX_FACTOR);
  localparam int DEPTH  = sum_depth(MAX_WIDTH, MAX_FACTOR);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_r;

  logic                s1_v_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [VOXEL_W-1:0]  s1_vox_r;
  cube_tag_t           s1_tag_r;

  logic                fwd_v_r;
  logic [ADDR_W-1:0]   fwd_addr_r;
  logic [SUM_W-1:0]    fwd_sum_r;

  logic                a_v_r;
  logic [SUM_W-1:0]    a_sum_r;
  cube_tag_t           a_tag_r;

  logic [SUM_W-1:0] vox_ext, base, sum;
  logic             wr;

  always_comb begin
    vox_ext = {{(SUM_W-VOXEL_W){s1_vox_r[VOXEL_W-1]}}, s1_vox_r};
    // the write of the previous transaction lands on the same edge as this read
    base = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_sum_r : rd_r;
    sum  = s1_tag_r.first ? vox_ext : base + vox_ext;
    wr   = en && s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= mem[in_addr];
    end
    if (wr) begin
      mem[s1_addr_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      a_v_r   <= 1'b0;
    end else begin
      if (en) begin
        s1_v_r <= in_v;
        a_v_r  <= s1_v_r && s1_tag_r.last;
      end
      if (wr) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_addr_r <= in_addr;
      s1_vox_r  <= in_voxel;
      s1_tag_r  <= in_tag;
      a_sum_r   <= sum;
      a_tag_r   <= s1_tag_r;
    end
    if (wr) begin
      fwd_addr_r <= s1_addr_r;
      fwd_sum_r  <= sum;
    end
  end

  assign out_v   = a_v_r;
  assign out_sum = a_sum_r;
  assign out_tag = a_tag_r;

endmodule

// File: hdl/vbad_div.sv
// Pipelined signed division by factor cubed via reciprocal multiply and one correction.
module vbad_div
  import vbad_pkg::*;
#(
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic [$clog2(MAX_FACTOR+1)-1:0]         f,
  input  logic                                    in_v,
  input  logic signed [sum_width(MAX_FACTOR)-1:0] in_sum,
  input  cube_tag_t                               in_tag,
  output logic                                    out_v,
  output logic signed [VOXEL_W-1:0]               out_q,
  output cube_tag_t                               out_tag
);

  localparam int SUM_W = sum_width(MAX_FACTOR);
  localparam int MAG_W = SUM_W - 1;
  localparam int K     = MAG_W;
  localparam int R_W   = MAG_W + 1;
  localparam int CW    = $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR + 1);
  localparam int QW    = VOXEL_W;
  localparam int P_W   = MAG_W + R_W;

  logic [R_W-1:0] rcp_tab  [MAX_FACTOR+1];
  logic [CW-1:0]  cube_tab [MAX_FACTOR+1];

  for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_tab
    localparam longint unsigned CUBE = (g == 0) ? 1 : g * g * g;
    localparam longint unsigned RCP  = (64'd1 << K) / CUBE;
    assign rcp_tab[g]  = R_W'(RCP);
    assign cube_tab[g] = CW'(CUBE);
  end

  logic [3:0]      v_r;
  cube_tag_t       tag_r [4];
  logic [3:0]      neg_r;
  logic [MAG_W-1:0] mag1_r, mag2_r, mag3_r;
  logic [R_W-1:0]  rcp1_r;
  logic [CW-1:0]   cube1_r, cube2_r, cube3_r;
  logic [QW-1:0]   q2_r, q3_r;
  logic [QW+CW-1:0] qd3_r;
  logic [QW-1:0]   res_r;

  logic [SUM_W-1:0] neg_sum;
  logic [P_W-1:0]   prod;
  logic [MAG_W-1:0] rem;
  logic [QW-1:0]    q_fix;

  always_comb begin
    neg_sum = -in_sum;
    prod    = P_W'(mag1_r) * P_W'(rcp1_r);
    // estimate is exact or one short
    rem     = mag3_r - MAG_W'(qd3_r);
    q_fix   = (rem >= MAG_W'(cube3_r)) ? q3_r + QW'(1) : q3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
      neg_r    <= {neg_r[2:0], in_sum[SUM_W-1]};

      mag1_r  <= MAG_W'(in_sum[SUM_W-1] ? neg_sum : in_sum);
      rcp1_r  <= rcp_tab[f];
      cube1_r <= cube_tab[f];

      q2_r    <= prod[K +: QW];
      mag2_r  <= mag1_r;
      cube2_r <= cube1_r;

      qd3_r   <= (QW+CW)'(q2_r) * (QW+CW)'(cube2_r);
      q3_r    <= q2_r;
      mag3_r  <= mag2_r;
      cube3_r <= cube2_r;

      res_r   <= neg_r[2] ? -q_fix : q_fix;
    end
  end

  assign out_v   = v_r[3];
  assign out_q   = res_r;
  assign out_tag = tag_r[3];

endmodule
